[rtl/arm_pkg.sv]
// Package: shared constants, types and state codes of the address range map table.
package arm_pkg;

   localparam int ADDR_WIDTH          = 64;
   localparam int OUT_TAG_WIDTH       = 32;
   localparam int TABLE_DEPTH_DEFAULT = 256;
   localparam int TAG_WIDTH_DEFAULT   = 32;
   // cells folded into one register of the first reduction level
   localparam int GROUP_SIZE          = 16;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_LOOKUP = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_GROUP,
      ST_FINAL
   } state_type;

   // broadcast from the controller to every cell
   typedef struct packed {
      logic                  ins_en;
      logic                  look_en;
      logic [ADDR_WIDTH-1:0] key;
      logic [ADDR_WIDTH-1:0] end_addr;
   } cell_cmd_type;

endpackage

[rtl/arm_if.sv]
// Interfaces: request and response channels of the address range map table.
interface arm_req_if;
   logic        valid;
   logic        ready;
   logic        operation;
   logic [63:0] range_start;
   logic [63:0] range_end;
   logic [31:0] map_tag;
   logic [63:0] lookup_address;

   modport source (output valid, operation, range_start, range_end, map_tag,
                   lookup_address, input ready);
   modport sink   (input valid, operation, range_start, range_end, map_tag,
                   lookup_address, output ready);
endinterface

interface arm_rsp_if;
   logic        valid;
   logic        ready;
   logic        hit;
   logic [31:0] found_tag;
   logic        table_full;

   modport source (output valid, hit, found_tag, table_full, input ready);
   modport sink   (input valid, hit, found_tag, table_full, output ready);
endinterface

[rtl/arm_cell.sv]
// One table cell: holds an entry, shifts right on insert, flags a lookup match.
module arm_cell #(
   parameter int TABLE_DEPTH = arm_pkg::TABLE_DEPTH_DEFAULT,
   parameter int TAG_WIDTH   = arm_pkg::TAG_WIDTH_DEFAULT,
   parameter int CELL_INDEX  = 0,
   localparam int CW         = $clog2(TABLE_DEPTH + 1)
) (
   input  logic                            clock,
   input  logic                            reset,
   input  arm_pkg::cell_cmd_type           cmd,
   input  logic [TAG_WIDTH-1:0]            new_tag,
   input  logic [CW-1:0]                   count,
   input  logic [arm_pkg::ADDR_WIDTH-1:0]  left_start,
   input  logic [arm_pkg::ADDR_WIDTH-1:0]  left_end,
   input  logic [TAG_WIDTH-1:0]            left_tag,
   input  logic                            left_gt,
   input  logic                            right_le,
   output logic [arm_pkg::ADDR_WIDTH-1:0]  start_out,
   output logic [arm_pkg::ADDR_WIDTH-1:0]  end_out,
   output logic [TAG_WIDTH-1:0]            tag_out,
   output logic                            gt,
   output logic                            le,
   output logic                            match
);

   localparam logic [CW-1:0] MY_INDEX = CW'(CELL_INDEX);

   logic [arm_pkg::ADDR_WIDTH-1:0] start_ff, start_in;
   logic [arm_pkg::ADDR_WIDTH-1:0] end_ff, end_in;
   logic [TAG_WIDTH-1:0]           tag_ff, tag_in;
   logic                           match_ff, match_in;
   logic                           occupied;
   logic                           above;
   logic                           at_pos;

   assign occupied = MY_INDEX < count;
   assign above    = start_ff > cmd.key;
   assign gt       = occupied & above;
   assign le       = occupied & ~above;
   // new entry lands here: left neighbor not above it, and this one is above or free
   assign at_pos   = ~left_gt & (gt | (count == MY_INDEX));

   always_comb begin
      start_in = start_ff;
      end_in   = end_ff;
      tag_in   = tag_ff;
      if (cmd.ins_en) begin
         if (left_gt) begin
            start_in = left_start;
            end_in   = left_end;
            tag_in   = left_tag;
         end else if (at_pos) begin
            start_in = cmd.key;
            end_in   = cmd.end_addr;
            tag_in   = new_tag;
         end
      end
   end

   // last entry not above the address, and the address below its end
   assign match_in = cmd.look_en ? (le & ~right_le & (cmd.key < end_ff)) : match_ff;

   always_ff @(posedge clock) begin
      start_ff <= start_in;
      end_ff   <= end_in;
      tag_ff   <= tag_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff <= 1'b0;
      end else begin
         match_ff <= match_in;
      end
   end

   assign start_out = start_ff;
   assign end_out   = end_ff;
   assign tag_out   = tag_ff;
   assign match     = match_ff;

endmodule

[rtl/arm_reduce.sv]
// Two-level reduction: registered per-group fold of cell matches, then a final fold.
module arm_reduce #(
   parameter int TABLE_DEPTH = arm_pkg::TABLE_DEPTH_DEFAULT,
   parameter int TAG_WIDTH   = arm_pkg::TAG_WIDTH_DEFAULT
) (
   input  logic                 clock,
   input  logic                 load,
   input  logic                 match [TABLE_DEPTH],
   input  logic [TAG_WIDTH-1:0] tags  [TABLE_DEPTH],
   output logic                 hit,
   output logic [TAG_WIDTH-1:0] tag
);

   localparam int G  = arm_pkg::GROUP_SIZE;
   localparam int NG = (TABLE_DEPTH + G - 1) / G;

   logic                 grp_hit_ff [NG];
   logic                 grp_hit_in [NG];
   logic [TAG_WIDTH-1:0] grp_tag_ff [NG];
   logic [TAG_WIDTH-1:0] grp_tag_in [NG];

   // at most one cell matches, so an OR of gated tags selects it
   always_comb begin
      for (int g = 0; g < NG; g++) begin
         grp_hit_in[g] = 1'b0;
         grp_tag_in[g] = '0;
         for (int j = 0; j < G; j++) begin
            if (g * G + j < TABLE_DEPTH) begin
               grp_hit_in[g] = grp_hit_in[g] | match[g * G + j];
               grp_tag_in[g] = grp_tag_in[g] |
                               (match[g * G + j] ? tags[g * G + j] : '0);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         grp_hit_ff <= grp_hit_in;
         grp_tag_ff <= grp_tag_in;
      end
   end

   always_comb begin
      hit = 1'b0;
      tag = '0;
      for (int g = 0; g < NG; g++) begin
         hit = hit | grp_hit_ff[g];
         tag = tag | grp_tag_ff[g];
      end
   end

endmodule

[rtl/address_range_map_table.sv]
// Top level: sorted address range map table built as a row of shifting cells.
//
// The table keeps up to TABLE_DEPTH mappings sorted by start address, one per
// cell. An insert request compares its start against every cell at once; cells
// above it shift one place right and the new entry drops into the gap, so the
// table is updated at the accepting clock edge and the response is valid in the
// next cycle. Equal starts land after the ones present. A full table refuses
// the insert and reports table_full. A lookup request has every cell test
// start <= address against its right neighbor, so exactly the last such cell
// checks address < end and registers a match; the matches are then folded
// through a registered group level (GROUP_SIZE cells per group) and a final
// level into the response register. A lookup result thus passes through the
// cell match register, the group register and the response register, and no
// request is taken while one is in flight. A new request is accepted while a
// finished response waits, provided it is taken in the same cycle or the
// output is empty. Entries are tracked by a count only: no clearing pass
// follows reset.
module address_range_map_table #(
   parameter int TABLE_DEPTH = arm_pkg::TABLE_DEPTH_DEFAULT,
   parameter int TAG_WIDTH   = arm_pkg::TAG_WIDTH_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   arm_req_if.sink   req,
   arm_rsp_if.source rsp
);

   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_DEPTH);

   arm_pkg::state_type    state_ff, state_in;
   arm_pkg::cell_cmd_type cmd;

   logic [CW-1:0] count_ff, count_in;
   logic          accept;
   logic          is_insert;
   logic          table_is_full;
   logic          grp_load;
   logic          fin_load;
   logic          req_ready;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          rsp_hit_ff, rsp_hit_in;
   logic [arm_pkg::OUT_TAG_WIDTH-1:0] rsp_tag_ff, rsp_tag_in;
   logic                          rsp_full_ff, rsp_full_in;

   logic [TAG_WIDTH-1:0] new_tag;
   logic                 red_hit;
   logic [TAG_WIDTH-1:0] red_tag;

   // cell row wiring
   logic [arm_pkg::ADDR_WIDTH-1:0] c_start [TABLE_DEPTH];
   logic [arm_pkg::ADDR_WIDTH-1:0] c_end   [TABLE_DEPTH];
   logic [TAG_WIDTH-1:0]           c_tag   [TABLE_DEPTH];
   logic                           c_gt    [TABLE_DEPTH];
   logic                           c_le    [TABLE_DEPTH];
   logic                           c_match [TABLE_DEPTH];

   // request handshake and decode
   assign accept        = req.valid & req_ready;
   assign is_insert     = req.operation == arm_pkg::OP_INSERT;
   assign table_is_full = count_ff == FULL_COUNT;
   assign new_tag       = TAG_WIDTH'(req.map_tag);

   // broadcast to cells: key is the new start on insert, the address on lookup
   always_comb begin
      cmd.ins_en   = accept & is_insert & ~table_is_full;
      cmd.look_en  = accept & ~is_insert;
      cmd.key      = is_insert ? req.range_start : req.lookup_address;
      cmd.end_addr = req.range_end;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         arm_pkg::ST_IDLE:  if (cmd.look_en) state_in = arm_pkg::ST_GROUP;
         arm_pkg::ST_GROUP: state_in = arm_pkg::ST_FINAL;
         arm_pkg::ST_FINAL: state_in = arm_pkg::ST_IDLE;
         default:           state_in = arm_pkg::ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_ready = 1'b0;
      grp_load  = 1'b0;
      fin_load  = 1'b0;
      unique case (state_ff)
         arm_pkg::ST_IDLE:  req_ready = ~rsp_valid_ff | rsp.ready;
         arm_pkg::ST_GROUP: grp_load  = 1'b1;
         arm_pkg::ST_FINAL: fin_load  = 1'b1;
         default:           req_ready = 1'b0;
      endcase
   end

   assign count_in = cmd.ins_en ? count_ff + 1'b1 : count_ff;

   // response register: load an insert result at once, a lookup at the final step
   always_comb begin
      rsp_hit_in  = rsp_hit_ff;
      rsp_tag_in  = rsp_tag_ff;
      rsp_full_in = rsp_full_ff;
      if (accept & is_insert) begin
         rsp_hit_in  = ~table_is_full;
         rsp_tag_in  = '0;
         rsp_full_in = table_is_full;
      end else if (fin_load) begin
         rsp_hit_in  = red_hit;
         rsp_tag_in  = arm_pkg::OUT_TAG_WIDTH'(red_tag);
         rsp_full_in = 1'b0;
      end
   end

   assign rsp_valid_in = (accept & is_insert) | fin_load |
                         (rsp_valid_ff & ~rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= arm_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_hit_ff  <= rsp_hit_in;
      rsp_tag_ff  <= rsp_tag_in;
      rsp_full_ff <= rsp_full_in;
   end

   // row of cells; each takes its left neighbor's entry on a shift
   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      logic [arm_pkg::ADDR_WIDTH-1:0] l_start;
      logic [arm_pkg::ADDR_WIDTH-1:0] l_end;
      logic [TAG_WIDTH-1:0]           l_tag;
      logic                           l_gt;
      logic                           r_le;

      if (i == 0) begin : g_first
         assign l_start = cmd.key;
         assign l_end   = cmd.end_addr;
         assign l_tag   = new_tag;
         assign l_gt    = 1'b0;
      end else begin : g_inner
         assign l_start = c_start[i-1];
         assign l_end   = c_end[i-1];
         assign l_tag   = c_tag[i-1];
         assign l_gt    = c_gt[i-1];
      end

      if (i == TABLE_DEPTH - 1) begin : g_last
         assign r_le = 1'b0;
      end else begin : g_mid
         assign r_le = c_le[i+1];
      end

      arm_cell #(
         .TABLE_DEPTH (TABLE_DEPTH),
         .TAG_WIDTH   (TAG_WIDTH),
         .CELL_INDEX  (i)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .new_tag    (new_tag),
         .count      (count_ff),
         .left_start (l_start),
         .left_end   (l_end),
         .left_tag   (l_tag),
         .left_gt    (l_gt),
         .right_le   (r_le),
         .start_out  (c_start[i]),
         .end_out    (c_end[i]),
         .tag_out    (c_tag[i]),
         .gt         (c_gt[i]),
         .le         (c_le[i]),
         .match      (c_match[i])
      );
   end

   arm_reduce #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .TAG_WIDTH   (TAG_WIDTH)
   ) u_reduce (
      .clock (clock),
      .load  (grp_load),
      .match (c_match),
      .tags  (c_tag),
      .hit   (red_hit),
      .tag   (red_tag)
   );

   assign req.ready      = req_ready;
   assign rsp.valid      = rsp_valid_ff;
   assign rsp.hit        = rsp_hit_ff;
   assign rsp.found_tag  = rsp_tag_ff;
   assign rsp.table_full = rsp_full_ff;

endmodule

[rtl/arm_checker.sv]
// Checker: port-level timing and response rules of the map table, bound to the top.
module arm_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        req_operation,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_hit,
   input logic [31:0] rsp_found_tag,
   input logic        rsp_table_full
);

   logic req_take;
   assign req_take = req_valid & req_ready;

   // hold a stalled response
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hit) &&
      $stable(rsp_found_tag) && $stable(rsp_table_full))
      else $error("stalled response changed");

   // an insert answers in the next cycle
   a_insert_lat: assert property (@(posedge clock) disable iff (reset)
      req_take && req_operation == arm_pkg::OP_INSERT |=> rsp_valid)
      else $error("insert response missing");

   // a lookup blocks new requests while it reduces, then answers
   a_lookup_busy: assert property (@(posedge clock) disable iff (reset)
      req_take && req_operation == arm_pkg::OP_LOOKUP |=> !req_ready)
      else $error("request taken during lookup");

   a_lookup_lat: assert property (@(posedge clock) disable iff (reset)
      req_take && req_operation == arm_pkg::OP_LOOKUP |-> ##3 rsp_valid)
      else $error("lookup response missing");

   // a miss or a refused insert carries no tag
   a_miss_tag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (!rsp_hit || rsp_table_full) |->
      rsp_found_tag == '0 && !(rsp_hit && rsp_table_full))
      else $error("tag on miss or refused insert");

endmodule

bind address_range_map_table arm_checker u_arm_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req.valid),
   .req_ready      (req.ready),
   .req_operation  (req.operation),
   .rsp_valid      (rsp.valid),
   .rsp_ready      (rsp.ready),
   .rsp_hit        (rsp.hit),
   .rsp_found_tag  (rsp.found_tag),
   .rsp_table_full (rsp.table_full)
);

[verif/address_range_map_table_test.sv]
// Testbench: self-checking random and directed test of the address range map table.
`timescale 1ns / 100ps

module address_range_map_table_test;

   localparam int DEPTH        = arm_pkg::TABLE_DEPTH_DEFAULT;
   localparam int TAG_W        = arm_pkg::TAG_WIDTH_DEFAULT;
   localparam int AW           = arm_pkg::ADDR_WIDTH;
   localparam int OTW          = arm_pkg::OUT_TAG_WIDTH;
   localparam int RANDOM_ITEMS = 750;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int HOLDOFF_AT   = 2000;
   localparam int HOLDOFF_LEN  = 400;
   localparam int DRAIN_CYCLES = 10;

   typedef struct packed {
      logic          operation;
      logic [AW-1:0] range_start;
      logic [AW-1:0] range_end;
      logic [31:0]   map_tag;
      logic [AW-1:0] lookup_address;
   } map_req_type;

   typedef struct packed {
      logic           hit;
      logic [OTW-1:0] found_tag;
      logic           table_full;
   } map_rsp_type;

   logic clock;
   logic reset;

   arm_req_if req_ch ();
   arm_rsp_if rsp_ch ();

   address_range_map_table u_top (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   always #5 clock = ~clock;

   // Requests waiting to be offered, and responses owed by the block.
   map_req_type request_backlog[$];
   map_rsp_type due_responses[$];

   // Shadow copy of the table, kept sorted by start exactly like the block.
   logic [AW-1:0]  shadow_start [DEPTH];
   logic [AW-1:0]  shadow_end   [DEPTH];
   logic [OTW-1:0] shadow_tag   [DEPTH];
   int             shadow_count;

   // Ranges handed to the stimulus so far, used to aim lookups at real entries.
   logic [AW-1:0] issued_start[$];
   logic [AW-1:0] issued_end[$];

   int          total_requests;
   int          requests_taken;
   int          failures;
   int          cycle_count;
   int          send_gap;
   map_req_type offered_req;
   int          stall_left;
   int          holdoff_left;
   int          pick;

   function automatic logic [AW-1:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   // Update the shadow table with one request and return the response it owes.
   function automatic map_rsp_type apply_request(map_req_type r);
      map_rsp_type    o;
      int             pos;
      int             k;
      int             sel;
      bit             found;
      logic [OTW-1:0] tag_keep;
      o        = '0;
      tag_keep = (TAG_W >= OTW) ? '1 : ((OTW'(1) << TAG_W) - 1'b1);
      if (r.operation == arm_pkg::OP_INSERT) begin
         if (shadow_count >= DEPTH) begin
            o.table_full = 1'b1;
         end else begin
            // equal starts go after those already present
            pos = 0;
            while (pos < shadow_count && shadow_start[pos] <= r.range_start) pos++;
            for (k = shadow_count; k > pos; k--) begin
               shadow_start[k] = shadow_start[k-1];
               shadow_end[k]   = shadow_end[k-1];
               shadow_tag[k]   = shadow_tag[k-1];
            end
            shadow_start[pos] = r.range_start;
            shadow_end[pos]   = r.range_end;
            shadow_tag[pos]   = r.map_tag & tag_keep;
            shadow_count++;
            o.hit = 1'b1;
         end
      end else begin
         // take the last entry whose start is not above the address
         found = 1'b0;
         sel   = 0;
         for (k = 0; k < shadow_count; k++) begin
            if (shadow_start[k] <= r.lookup_address) begin
               found = 1'b1;
               sel   = k;
            end
         end
         if (found && r.lookup_address < shadow_end[sel]) begin
            o.hit       = 1'b1;
            o.found_tag = shadow_tag[sel];
         end
      end
      return o;
   endfunction

   // Queue an insert; leave the unused lookup field random.
   task automatic add_insert(logic [AW-1:0] s, logic [AW-1:0] e, logic [31:0] tag);
      map_req_type r;
      r.operation      = arm_pkg::OP_INSERT;
      r.range_start    = s;
      r.range_end      = e;
      r.map_tag        = tag;
      r.lookup_address = rand64();
      request_backlog.push_back(r);
      issued_start.push_back(s);
      issued_end.push_back(e);
   endtask

   // Queue a lookup; leave the unused insert fields random.
   task automatic add_lookup(logic [AW-1:0] a);
      map_req_type r;
      r.operation      = arm_pkg::OP_LOOKUP;
      r.range_start    = rand64();
      r.range_end      = rand64();
      r.map_tag        = $urandom();
      r.lookup_address = a;
      request_backlog.push_back(r);
   endtask

   // Quiet windows: one stretch in every four runs with no random idling.
   function automatic bit quiet_window();
      return ((cycle_count / 500) % 4) == 1;
   endfunction

   // Stimulus, reset and end of run.
   initial begin : stimulus
      int            n;
      int            idx;
      logic [AW-1:0] s;
      logic [AW-1:0] e;
      logic [AW-1:0] len;
      clock                 = 1'b0;
      reset                 = 1'b1;
      req_ch.valid          = 1'b0;
      req_ch.operation      = arm_pkg::OP_INSERT;
      req_ch.range_start    = '0;
      req_ch.range_end      = '0;
      req_ch.map_tag        = '0;
      req_ch.lookup_address = '0;
      rsp_ch.ready          = 1'b0;

      // Directed part: empty table first.
      add_lookup('0);
      add_lookup('1);
      add_insert(64'd100, 64'd200, 32'h0000_00a1);
      add_lookup(64'd99);                          // below every start
      add_lookup(64'd100);
      add_lookup(64'd199);
      add_lookup(64'd200);                         // end is exclusive
      add_insert(64'd150, 64'd300, 32'h0000_00b2); // overlaps the first range
      add_lookup(64'd160);
      add_lookup(64'd120);
      add_insert(64'd100, 64'd110, 32'h0000_00c3); // equal start lands after
      add_lookup(64'd105);
      add_lookup(64'd115);
      add_insert(64'd400, 64'd400, 32'h0000_00d4); // empty range
      add_lookup(64'd400);
      add_insert(64'd500, 64'd450, 32'h0000_00e5); // reversed range
      add_lookup(64'd460);
      add_insert('1, '1, 32'h8000_0000);
      add_insert('0, '1, '1);
      add_lookup('1);
      add_lookup('0);
      add_lookup(64'hffff_ffff_ffff_fffe);

      // Random part: mostly well-formed ranges and lookups aimed at them.
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 50) begin
            pick = $urandom_range(0, 99);
            idx  = $urandom_range(0, issued_start.size() - 1);
            len  = AW'($urandom_range(1, 1 << $urandom_range(0, 20)));
            if (pick < 70) begin
               s = rand64();
               e = s + len;
            end else if (pick < 80) begin
               s = issued_start[idx];
               e = s + len;
            end else if (pick < 90) begin
               s = issued_start[idx] + (len >> 1);
               e = s + len;
            end else if (pick < 95) begin
               s = rand64();
               e = ($urandom_range(0, 1) != 0) ? s : s - len;
            end else begin
               s = ($urandom_range(0, 1) != 0) ? '0 : '1;
               e = rand64();
            end
            add_insert(s, e, $urandom());
         end else begin
            pick = $urandom_range(0, 99);
            idx  = $urandom_range(0, issued_start.size() - 1);
            s    = issued_start[idx];
            e    = issued_end[idx];
            if (pick < 20)      add_lookup(s);
            else if (pick < 35) add_lookup(e - 1'b1);
            else if (pick < 55) add_lookup(s + ((e - s) >> $urandom_range(1, 8)));
            else if (pick < 65) add_lookup(e);
            else if (pick < 75) add_lookup(s - 1'b1);
            else if (pick < 95) add_lookup(rand64());
            else                add_lookup(($urandom_range(0, 1) != 0) ? '0 : '1);
         end
      end
      total_requests = request_backlog.size();

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Hold until every request is taken and every response is back.
      while (requests_taken < total_requests || due_responses.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (failures == 0 && due_responses.size() == 0) begin
         $display("address_range_map_table: match");
      end else begin
         $display("address_range_map_table: mismatch");
      end
      $finish;
   end

   // Request driver: predict on acceptance, then offer the next request or idle.
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid   <= 1'b0;
         send_gap       = 0;
         requests_taken = 0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            due_responses.push_back(apply_request(offered_req));
            requests_taken++;
         end
         // only change the offer when nothing is pending on the channel
         if (!req_ch.valid || req_ch.ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_ch.valid <= 1'b0;
            end else if (request_backlog.size() > 0) begin
               offered_req            = request_backlog.pop_front();
               req_ch.operation      <= offered_req.operation;
               req_ch.range_start    <= offered_req.range_start;
               req_ch.range_end      <= offered_req.range_end;
               req_ch.map_tag        <= offered_req.map_tag;
               req_ch.lookup_address <= offered_req.lookup_address;
               req_ch.valid          <= 1'b1;
               pick = $urandom_range(0, 99);
               if (quiet_window() || pick < 55) send_gap = 0;
               else if (pick < 90)             send_gap = $urandom_range(1, 3);
               else                            send_gap = $urandom_range(10, 40);
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // Response ready: random stalls, plus one long hold-off that backs up the input.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         stall_left   = 0;
         holdoff_left = 0;
      end else if (cycle_count == HOLDOFF_AT) begin
         holdoff_left = HOLDOFF_LEN;
         rsp_ch.ready <= 1'b0;
      end else if (holdoff_left > 0) begin
         holdoff_left--;
         rsp_ch.ready <= 1'b0;
      end else if (quiet_window()) begin
         stall_left = 0;
         rsp_ch.ready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ch.ready <= 1'b0;
      end else begin
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            rsp_ch.ready <= 1'b1;
         end else if (pick < 95) begin
            rsp_ch.ready <= 1'b0;
            stall_left = $urandom_range(0, 3);
         end else begin
            rsp_ch.ready <= 1'b0;
            stall_left = $urandom_range(10, 40);
         end
      end
   end

   // Response monitor: compare each taken response with the oldest expectation.
   always @(posedge clock) begin : monitor
      map_rsp_type want;
      map_rsp_type got;
      if (reset) begin
         failures = 0;
      end else if (rsp_ch.valid && rsp_ch.ready) begin
         got.hit        = rsp_ch.hit;
         got.found_tag  = rsp_ch.found_tag;
         got.table_full = rsp_ch.table_full;
         if (due_responses.size() == 0) begin
            if (failures < 10)
               $display("unexpected response: hit=%0b tag=%h full=%0b",
                        got.hit, got.found_tag, got.table_full);
            failures++;
         end else begin
            want = due_responses.pop_front();
            if (got.hit !== want.hit || got.found_tag !== want.found_tag ||
                got.table_full !== want.table_full) begin
               if (failures < 10)
                  $display({"response %0d: expected hit=%0b tag=%h full=%0b, ",
                            "got hit=%0b tag=%h full=%0b"},
                           requests_taken - due_responses.size() - 1,
                           want.hit, want.found_tag, want.table_full,
                           got.hit, got.found_tag, got.table_full);
               failures++;
            end
         end
      end
   end

   // Cycle counter and watchdog.
   always @(posedge clock) begin
      if (reset) begin
         cycle_count <= 0;
      end else begin
         cycle_count <= cycle_count + 1;
         if (cycle_count >= CYCLE_LIMIT) begin
            $display("address_range_map_table: mismatch");
            $finish;
         end
      end
   end

endmodule

[address_range_map_table.f]
rtl/arm_pkg.sv
rtl/arm_if.sv
rtl/arm_cell.sv
rtl/arm_reduce.sv
rtl/address_range_map_table.sv
rtl/arm_checker.sv
verif/address_range_map_table_test.sv
